[design/aimd_barrier_message_pacer_defines.svh]
// Assertion macros shared by the pacer's checking code.
`ifndef AIMD_BARRIER_MESSAGE_PACER_DEFINES_SVH
`define AIMD_BARRIER_MESSAGE_PACER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AIMD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aimd pacer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define AIMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aimd pacer: next-cycle check failed");

`endif

[design/aimd_bmp_pkg.sv]
package aimd_bmp_pkg;

   // Request kinds.
   localparam logic [1:0] KIND_ENQUEUE = 2'd0;
   localparam logic [1:0] KIND_POLL    = 2'd1;
   localparam logic [1:0] KIND_REPLY   = 2'd2;

   // Result kinds.
   localparam logic [1:0] RES_FORWARD = 2'd0;
   localparam logic [1:0] RES_BARRIER = 2'd1;
   localparam logic [1:0] RES_DROP    = 2'd2;

   // Register map: index is byte address divided by four.
   localparam int         CSR_ADDR_W        = 4;
   localparam logic [1:0] REG_INITIAL_LIMIT = 2'd0;
   localparam logic [1:0] REG_ADDITIVE_STEP = 2'd1;
   localparam logic [1:0] REG_DECREASE_RAT  = 2'd2;
   localparam logic [1:0] REG_WAIT_INTERVAL = 2'd3;

   localparam logic [31:0] INITIAL_LIMIT_RST = 32'd100;
   localparam logic [15:0] ADDITIVE_STEP_RST = 16'd5;
   localparam logic [7:0]  DECREASE_RAT_RST  = 8'd2;
   localparam logic [31:0] WAIT_INTERVAL_RST = 32'd5000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] msg_handle;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] out_handle;
      logic [31:0] limit_now;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] initial_limit;
      logic [15:0] additive_step;
      logic [7:0]  decrease_ratio;
      logic [31:0] wait_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic latch_req;
      logic enq_write;
      logic mark_reply;
      logic grow_limit;
      logic div_start;
      logic emit_fwd;
      logic emit_drop;
      logic emit_barrier;
      logic clear_sent;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       full;
      logic       nonempty;
      logic       pending;
      logic       reply;
      logic       timeout;
      logic       can_release;
      logic       count_one;
      logic       hit_limit;
      logic       div_done;
   } status_type;

endpackage

[design/aimd_bmp_ram.sv]
module aimd_bmp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/aimd_bmp_csr.sv]
module aimd_bmp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [aimd_bmp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output aimd_bmp_pkg::cfg_type               cfg,
   output logic                                limit_load
);

   aimd_bmp_pkg::cfg_type cfg_ff, cfg_in;
   logic                  limit_load_ff, limit_load_in;
   logic                  wr_strobe;
   logic [1:0]            reg_index;

   assign pready    = 1'b1;
   assign wr_strobe = psel & penable & pwrite;
   assign reg_index = paddr[3:2];

   // The reload pulse comes in the cycle after the write, when cfg already holds the new value.
   always_comb begin
      cfg_in        = cfg_ff;
      limit_load_in = 1'b0;
      if (wr_strobe) begin
         case (reg_index)
            aimd_bmp_pkg::REG_INITIAL_LIMIT: begin
               cfg_in.initial_limit = pwdata;
               limit_load_in        = 1'b1;
            end
            aimd_bmp_pkg::REG_ADDITIVE_STEP: cfg_in.additive_step = pwdata[15:0];
            aimd_bmp_pkg::REG_DECREASE_RAT:  cfg_in.decrease_ratio = pwdata[7:0];
            aimd_bmp_pkg::REG_WAIT_INTERVAL: cfg_in.wait_interval_ms = pwdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         aimd_bmp_pkg::REG_INITIAL_LIMIT: prdata = cfg_ff.initial_limit;
         aimd_bmp_pkg::REG_ADDITIVE_STEP: prdata = {16'd0, cfg_ff.additive_step};
         aimd_bmp_pkg::REG_DECREASE_RAT:  prdata = {24'd0, cfg_ff.decrease_ratio};
         aimd_bmp_pkg::REG_WAIT_INTERVAL: prdata = cfg_ff.wait_interval_ms;
         default: prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_limit    <= aimd_bmp_pkg::INITIAL_LIMIT_RST;
         cfg_ff.additive_step    <= aimd_bmp_pkg::ADDITIVE_STEP_RST;
         cfg_ff.decrease_ratio   <= aimd_bmp_pkg::DECREASE_RAT_RST;
         cfg_ff.wait_interval_ms <= aimd_bmp_pkg::WAIT_INTERVAL_RST;
         limit_load_ff           <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         limit_load_ff <= limit_load_in;
      end
   end

   assign cfg        = cfg_ff;
   assign limit_load = limit_load_ff;

endmodule

[design/aimd_bmp_datapath.sv]
module aimd_bmp_datapath #(
   parameter int QUEUE_DEPTH = 32,
   parameter int MIN_LIMIT   = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  aimd_bmp_pkg::req_type    req_item,
   input  aimd_bmp_pkg::cfg_type    cfg,
   input  logic                     limit_load,
   input  aimd_bmp_pkg::cmd_type    cmd,
   output aimd_bmp_pkg::status_type status,
   output logic                     rsp_valid,
   output aimd_bmp_pkg::rsp_type    rsp_item
);

   localparam int              AW         = $clog2(QUEUE_DEPTH);
   localparam int              CW         = $clog2(QUEUE_DEPTH + 1);
   localparam int              DIV_STEPS  = 32;
   localparam int              DCW        = $clog2(DIV_STEPS);
   localparam logic [AW-1:0]   LAST_ADDR  = AW'(QUEUE_DEPTH - 1);
   localparam logic [AW:0]     DEPTH_X    = (AW + 1)'(QUEUE_DEPTH);
   localparam logic [CW-1:0]   FULL_COUNT = CW'(QUEUE_DEPTH);
   localparam logic [CW-1:0]   ONE_COUNT  = CW'(1);
   localparam logic [DCW-1:0]  DIV_LAST   = DCW'(DIV_STEPS - 1);
   localparam logic [31:0]     MIN_LIM_W  = 32'(MIN_LIMIT);
   localparam logic [15:0]     MIN_LIM_N  = 16'(MIN_LIMIT);

   aimd_bmp_pkg::req_type req_ff, req_in;
   aimd_bmp_pkg::rsp_type rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [31:0]           limit_ff, limit_in;
   logic [31:0]           sent_ff, sent_in;
   logic                  pending_ff, pending_in;
   logic                  reply_ff, reply_in;
   logic [31:0]           btime_ff, btime_in;
   logic [31:0]           quo_ff, quo_in;
   logic [7:0]            rem_ff, rem_in;
   logic [7:0]            dvs_ff, dvs_in;
   logic [DCW-1:0]        dcnt_ff, dcnt_in;
   logic                  drun_ff, drun_in;
   logic                  floor_ff, floor_in;

   logic [AW:0]   tail_sum;
   logic [AW-1:0] tail_addr;
   logic [AW-1:0] head_step;
   logic [31:0]   rd_data;
   logic          wr_en;
   logic [32:0]   grow_sum;
   logic [32:0]   sent_plus;
   logic [7:0]    ratio_eff;
   logic [23:0]   shrink_bound;
   logic [8:0]    trial;
   logic [8:0]    trial_diff;
   logic          trial_ge;
   logic          last_fwd;

   // Write slot is head plus fill, folded back into the queue.
   assign tail_sum  = (AW + 1)'(head_ff) + (AW + 1)'(count_ff);
   assign tail_addr = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : tail_sum[AW-1:0];
   assign head_step = (head_ff == LAST_ADDR) ? '0 : head_ff + AW'(1);

   assign grow_sum     = {1'b0, limit_ff} + 33'(cfg.additive_step);
   assign sent_plus    = {1'b0, sent_ff} + 33'd1;
   assign ratio_eff    = (cfg.decrease_ratio == 8'd0) ? 8'd1 : cfg.decrease_ratio;
   assign shrink_bound = 24'(ratio_eff) * 24'(MIN_LIM_N);

   // One restoring divide step per cycle.
   assign trial      = {rem_ff, quo_ff[31]};
   assign trial_ge   = trial >= {1'b0, dvs_ff};
   assign trial_diff = trial - {1'b0, dvs_ff};

   assign status.kind        = req_ff.kind;
   assign status.full        = count_ff == FULL_COUNT;
   assign status.nonempty    = count_ff != '0;
   assign status.pending     = pending_ff;
   assign status.reply       = reply_ff;
   assign status.timeout     = (req_ff.now_ms - btime_ff) > cfg.wait_interval_ms;
   assign status.can_release = (count_ff != '0) && (sent_ff < limit_ff);
   assign status.count_one   = count_ff == ONE_COUNT;
   assign status.hit_limit   = sent_plus == {1'b0, limit_ff};
   assign status.div_done    = drun_ff && (dcnt_ff == DIV_LAST);

   assign last_fwd = status.count_one && !status.hit_limit;

   always_comb begin
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      head_in      = head_ff;
      count_in     = count_ff;
      limit_in     = limit_ff;
      sent_in      = sent_ff;
      pending_in   = pending_ff;
      reply_in     = reply_ff;
      btime_in     = btime_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      dcnt_in      = dcnt_ff;
      drun_in      = drun_ff;
      floor_in     = floor_ff;
      wr_en        = 1'b0;

      if (cmd.latch_req) begin
         req_in = req_item;
      end
      if (cmd.enq_write) begin
         wr_en    = 1'b1;
         count_in = count_ff + ONE_COUNT;
      end
      if (cmd.mark_reply) begin
         reply_in = 1'b1;
      end
      if (cmd.grow_limit) begin
         limit_in   = grow_sum[32] ? 32'hFFFF_FFFF : grow_sum[31:0];
         pending_in = 1'b0;
         reply_in   = 1'b0;
      end
      if (cmd.div_start) begin
         quo_in   = limit_ff;
         rem_in   = 8'd0;
         dvs_in   = ratio_eff;
         dcnt_in  = '0;
         drun_in  = 1'b1;
         floor_in = limit_ff < 32'(shrink_bound);
      end
      if (drun_ff) begin
         rem_in  = trial_ge ? trial_diff[7:0] : trial[7:0];
         quo_in  = {quo_ff[30:0], trial_ge};
         dcnt_in = dcnt_ff + DCW'(1);
         if (dcnt_ff == DIV_LAST) begin
            drun_in  = 1'b0;
            limit_in = floor_ff ? MIN_LIM_W : {quo_ff[30:0], trial_ge};
         end
      end
      if (cmd.emit_fwd) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{aimd_bmp_pkg::RES_FORWARD, rd_data, limit_ff, last_fwd};
         head_in      = head_step;
         count_in     = count_ff - ONE_COUNT;
         sent_in      = sent_plus[31:0];
      end
      if (cmd.emit_drop) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{aimd_bmp_pkg::RES_DROP, req_ff.msg_handle, limit_ff, 1'b1};
      end
      if (cmd.emit_barrier) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{aimd_bmp_pkg::RES_BARRIER, 32'd0, limit_ff, 1'b1};
         pending_in   = 1'b1;
         reply_in     = 1'b0;
         btime_in     = req_ff.now_ms;
         if (cmd.clear_sent) begin
            sent_in = 32'd0;
         end
      end
      if (limit_load) begin
         limit_in = cfg.initial_limit;
      end
   end

   // Reading at the next head address keeps the head entry ready on rd_data in the cycle after.
   aimd_bmp_ram #(
      .WIDTH (32),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_addr),
      .wr_data (req_ff.msg_handle),
      .rd_addr (head_in),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         limit_ff     <= aimd_bmp_pkg::INITIAL_LIMIT_RST;
         sent_ff      <= 32'd0;
         pending_ff   <= 1'b0;
         reply_ff     <= 1'b0;
         btime_ff     <= 32'd0;
         drun_ff      <= 1'b0;
         dcnt_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         sent_ff      <= sent_in;
         pending_ff   <= pending_in;
         reply_ff     <= reply_in;
         btime_ff     <= btime_in;
         drun_ff      <= drun_in;
         dcnt_ff      <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      floor_ff <= floor_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

[design/aimd_bmp_ctrl.sv]
module aimd_bmp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  aimd_bmp_pkg::status_type status,
   output aimd_bmp_pkg::cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_DECIDE    = 7'b0000010,
      ST_FETCH     = 7'b0000100,
      ST_EMIT      = 7'b0001000,
      ST_PACK_BAR  = 7'b0010000,
      ST_DIVIDE    = 7'b0100000,
      ST_TIME_BAR  = 7'b1000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
            case (status.kind)
               aimd_bmp_pkg::KIND_ENQUEUE: begin
                  if (status.full) begin
                     cmd.emit_drop = 1'b1;
                  end else begin
                     cmd.enq_write = 1'b1;
                  end
               end
               aimd_bmp_pkg::KIND_REPLY: begin
                  cmd.mark_reply = status.pending;
               end
               aimd_bmp_pkg::KIND_POLL: begin
                  if (status.nonempty) begin
                     if (status.pending && status.reply) begin
                        cmd.grow_limit = 1'b1;
                        state_in       = ST_FETCH;
                     end else if (status.pending) begin
                        if (status.timeout) begin
                           cmd.div_start = 1'b1;
                           state_in      = ST_DIVIDE;
                        end
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_FETCH: begin
            state_in = status.can_release ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            cmd.emit_fwd = 1'b1;
            if (status.hit_limit) begin
               state_in = ST_PACK_BAR;
            end else if (status.count_one) begin
               state_in = ST_IDLE;
            end
         end
         ST_PACK_BAR: begin
            cmd.emit_barrier = 1'b1;
            cmd.clear_sent   = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_TIME_BAR;
            end
         end
         ST_TIME_BAR: begin
            cmd.emit_barrier = 1'b1;
            state_in         = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

endmodule

[design/aimd_barrier_message_pacer.sv]
// Paces control messages for one link under an additive-increase and
// multiplicative-decrease limit, with barriers marking the end of each pack.
// A request is taken on a rising edge where start is high and busy is low;
// req_item carries the kind (enqueue, poll with time, barrier reply), the
// message handle and the current time. Results appear on rsp_item for exactly
// one cycle, marked by rsp_valid, and the final result of a request has last
// set. The receiver cannot hold results off, so each one is complete the
// cycle it is shown. An enqueue or reply holds busy high for one cycle after
// acceptance, in the decide state; a dropped enqueue's result is registered
// from that state. A poll that releases queued handles passes the decide and
// fetch states, then sends one handle per cycle out of the queue RAM, plus
// a barrier when the limit is reached. A poll on a non-empty queue that times
// out runs the 32-step shift-and-subtract divider and then sends its barrier.
// No new request is taken while busy is high, so the release loop and the
// divider hold off the next one. Reset is synchronous: the state machine
// returns to idle, the queue empties, and registers take their defaults
// (limit 100, step 5, ratio 2, wait 5000 ms). The user must write registers
// on the APB-style port only while busy is low; the block itself does not
// enforce it.
`include "aimd_barrier_message_pacer_defines.svh"

module aimd_barrier_message_pacer #(
   parameter int QUEUE_DEPTH = 32,
   parameter int MIN_LIMIT   = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  aimd_bmp_pkg::req_type               req_item,
   output logic                                rsp_valid,
   output aimd_bmp_pkg::rsp_type               rsp_item,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [aimd_bmp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   aimd_bmp_pkg::cfg_type    cfg;
   aimd_bmp_pkg::cmd_type    cmd;
   aimd_bmp_pkg::status_type status;
   logic                     limit_load;

   // The register block also signals when the starting limit is rewritten,
   // which reloads the working limit in the datapath from the registered pulse.
   aimd_bmp_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .cfg        (cfg),
      .limit_load (limit_load)
   );

   // The sequencer decides what a request does and walks the release loop.
   aimd_bmp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // The datapath holds the queue, the limit arithmetic and the result register.
   aimd_bmp_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MIN_LIMIT   (MIN_LIMIT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cfg        (cfg),
      .limit_load (limit_load),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

   // An accepted request always holds the block busy for the next cycle.
   `AIMD_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // Results of one request come out in consecutive cycles until the last.
   `AIMD_ASSERT_NEXT(a_burst_contig, clock, reset, rsp_valid && !rsp_item.last, rsp_valid)
   // The last result of one request is never followed directly by another.
   `AIMD_ASSERT_NEXT(a_last_gap, clock, reset, rsp_valid && rsp_item.last, !rsp_valid)
   // A barrier always closes the results of its request.
   `AIMD_ASSERT_SAME(a_barrier_last, clock, reset,
      rsp_valid && (rsp_item.result_kind == aimd_bmp_pkg::RES_BARRIER), rsp_item.last)

endmodule

[test/tb_aimd_barrier_message_pacer.sv]
module tb_aimd_barrier_message_pacer;
   timeunit 1ns;
   timeprecision 1ps;

   // Sizes of the pacer as built, and the pacing of the run.
   localparam int QUEUE_DEPTH     = 32;
   localparam int MIN_LIMIT       = 20;
   localparam int DRAIN_CYCLES    = 40;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 45;
   localparam int MAX_REPORTS     = 40;

   // The request kind that the pacer leaves alone.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_op_type;

   // One row of the directed table. A request row sends reps requests whose
   // handle counts up from arg_a, all with time arg_b; a configuration row
   // writes arg_a to register sel. A pinned row carries its single expected
   // result in the last three columns instead of taking it from the predictor.
   typedef struct {
      row_op_type  op;
      logic [1:0]  sel;
      logic [31:0] arg_a;
      logic [31:0] arg_b;
      int          reps;
      bit          pinned;
      logic [1:0]  pin_kind;
      logic [31:0] pin_handle;
      logic [31:0] pin_limit;
   } stim_row_type;

   // Travels alongside each request from the sender to the monitor.
   typedef struct packed {
      logic                  pinned;
      aimd_bmp_pkg::rsp_type rsp;
   } pinned_result_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   aimd_bmp_pkg::req_type req_item;
   logic                  rsp_valid;
   aimd_bmp_pkg::rsp_type rsp_item;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [aimd_bmp_pkg::CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   aimd_barrier_message_pacer u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // Our own picture of the pacer: its registers, its handle queue and the
   // barrier bookkeeping, all at the widths the block uses.
   logic [31:0] cfg_initial_limit;
   logic [15:0] cfg_additive_step;
   logic [7:0]  cfg_decrease_ratio;
   logic [31:0] cfg_wait_ms;

   logic [31:0] exp_queue_mem [QUEUE_DEPTH];
   logic [4:0]  exp_head;
   logic [5:0]  exp_count;
   logic [31:0] exp_limit;
   logic [31:0] exp_sent;
   logic        exp_barrier_out;
   logic        exp_reply_seen;
   logic [31:0] exp_barrier_ms;

   // Results that the pacer still owes us, oldest first, and the pinned
   // expectations of requests that have been offered but not yet taken.
   aimd_bmp_pkg::rsp_type pending_results [$];
   pinned_result_type     pin_queue [$];

   int          errors;
   int unsigned cycle_count;

   // Millisecond clock of the random part and how far it moves per request.
   logic [31:0] sim_ms;
   int unsigned ms_stride;

   // The directed part. It starts from the reset settings (limit 100, step 5,
   // ratio 2, wait 5000), so the first rows also show that the registers came
   // out of reset with their documented values.
   stim_row_type directed_table [43] = '{
      // A poll with nothing queued, a reply with no barrier out and the
      // unused kind must all pass without a result.
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_POLL,    32'h0000_0000, 32'h0000_0000,  1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_REPLY,   32'h0000_0000, 32'h0000_0000,  1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, KIND_UNUSED,                32'hFFFF_FFFF, 32'hFFFF_FFFF,  1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      // Extreme handles, then a poll that forwards both.
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_ENQUEUE, 32'h0000_0000, 32'h0000_0000,  1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_ENQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,  1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_POLL,    32'h0000_0000, 32'hFFFF_FFFF,  1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      // Fill the queue to the brim; the next enqueue is dropped.
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_ENQUEUE, 32'h0000_0100, 32'h0000_0000, 32, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_ENQUEUE, 32'hDEAD_0000, 32'h0000_0000,  1, 1'b1,
        aimd_bmp_pkg::RES_DROP,    32'hDEAD_0000, 32'd100},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_POLL,    32'h0000_0000, 32'h0000_000A,  1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      // A limit already below the count sent since the last barrier holds
      // everything back; raising it just past that count ends the pack.
      '{ROW_CONFIG,  aimd_bmp_pkg::REG_INITIAL_LIMIT, 32'd3,   32'h0, 1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_CONFIG,  aimd_bmp_pkg::REG_WAIT_INTERVAL, 32'd100, 32'h0, 1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_ENQUEUE, 32'h0000_0200, 32'h0000_0000,  4, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_POLL,    32'h0000_0000, 32'd1000,       1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_CONFIG,  aimd_bmp_pkg::REG_INITIAL_LIMIT, 32'd36,  32'h0, 1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_POLL,    32'h0000_0000, 32'd1000,       1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      // Exactly the wait interval is not yet a timeout; one more is, and the
      // limit of 36 falls to the floor of 20.
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_POLL,    32'h0000_0000, 32'd1100,       1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_POLL,    32'h0000_0000, 32'd1101,       1, 1'b1,
        aimd_bmp_pkg::RES_BARRIER, 32'h0, 32'd20},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_REPLY,   32'h0000_0000, 32'h0000_0000,  1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_POLL,    32'h0000_0000, 32'h0000_0000,  1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      // A zero limit releases nothing.
      '{ROW_CONFIG,  aimd_bmp_pkg::REG_INITIAL_LIMIT, 32'd0,   32'h0, 1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_ENQUEUE, 32'h0000_0300, 32'h0000_0000,  1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_POLL,    32'h0000_0000, 32'd5,          1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_CONFIG,  aimd_bmp_pkg::REG_INITIAL_LIMIT, 32'd3,   32'h0, 1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_POLL,    32'h0000_0000, 32'd7,          1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      // The increase saturates at the top of the range.
      '{ROW_CONFIG,  aimd_bmp_pkg::REG_INITIAL_LIMIT, 32'hFFFF_FFFF, 32'h0, 1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_CONFIG,  aimd_bmp_pkg::REG_ADDITIVE_STEP, 32'h0000_FFFF, 32'h0, 1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_REPLY,   32'h0000_0000, 32'h0000_0000,  1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_ENQUEUE, 32'hA5A5_A5A5, 32'h0000_0000,  1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_POLL,    32'h0000_0000, 32'd8,          1, 1'b1,
        aimd_bmp_pkg::RES_FORWARD, 32'hA5A5_A5A5, 32'hFFFF_FFFF},
      // A zero ratio divides by one; a zero wait times out after any delay.
      '{ROW_CONFIG,  aimd_bmp_pkg::REG_DECREASE_RAT,  32'd0,   32'h0, 1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_CONFIG,  aimd_bmp_pkg::REG_WAIT_INTERVAL, 32'd0,   32'h0, 1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_CONFIG,  aimd_bmp_pkg::REG_INITIAL_LIMIT, 32'd2,   32'h0, 1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_ENQUEUE, 32'h0000_0400, 32'h0000_0000,  2, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_POLL,    32'h0000_0000, 32'd20,         1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_CONFIG,  aimd_bmp_pkg::REG_INITIAL_LIMIT, 32'd1000, 32'h0, 1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_POLL,    32'h0000_0000, 32'd20,         1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_POLL,    32'h0000_0000, 32'd21,         1, 1'b1,
        aimd_bmp_pkg::RES_BARRIER, 32'h0, 32'd1000},
      // The widest ratio, first against the floor and then on the largest
      // limit.
      '{ROW_CONFIG,  aimd_bmp_pkg::REG_DECREASE_RAT,  32'd255, 32'h0, 1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_POLL,    32'h0000_0000, 32'd22,         1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_CONFIG,  aimd_bmp_pkg::REG_INITIAL_LIMIT, 32'hFFFF_FFFF, 32'h0, 1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_POLL,    32'h0000_0000, 32'd23,         1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_REPLY,   32'h0000_0000, 32'h0000_0000,  1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0},
      '{ROW_REQUEST, aimd_bmp_pkg::KIND_POLL,    32'h0000_0000, 32'hFFFF_FFFF,  1, 1'b0,
        aimd_bmp_pkg::RES_FORWARD, 32'h0, 32'h0}
   };

   // The testbench clock runs free from time zero.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic aimd_bmp_pkg::rsp_type make_result(input logic [1:0]  kind,
                                                         input logic [31:0] handle);
      make_result = '{result_kind: kind, out_handle: handle, limit_now: 32'd0, last: 1'b0};
   endfunction

   // Works out what one accepted request does to the pacer and which results
   // it owes for it. A pinned expectation replaces the computed results, but
   // the state is moved on in the same way either way.
   task automatic pace_request(input aimd_bmp_pkg::req_type r, input pinned_result_type pin);
      aimd_bmp_pkg::rsp_type outs [$];
      logic [4:0]  slot;
      logic [31:0] in_pack;
      logic [31:0] elapsed;
      logic [31:0] ratio;
      logic [63:0] bound;
      logic [32:0] grown;
      bit          release_ok;
      release_ok = 1'b0;
      case (r.kind)
         aimd_bmp_pkg::KIND_ENQUEUE: begin
            if (exp_count >= QUEUE_DEPTH) begin
               outs.push_back(make_result(aimd_bmp_pkg::RES_DROP, r.msg_handle));
            end else begin
               slot = exp_head + exp_count[4:0];
               exp_queue_mem[slot] = r.msg_handle;
               exp_count++;
            end
         end
         aimd_bmp_pkg::KIND_REPLY: begin
            if (exp_barrier_out) exp_reply_seen = 1'b1;
         end
         aimd_bmp_pkg::KIND_POLL: begin
            // An empty queue makes the poll a no-op, even with a reply in hand.
            if (exp_count != 0) begin
               release_ok = 1'b1;
               if (exp_barrier_out) begin
                  if (exp_reply_seen) begin
                     grown = {1'b0, exp_limit} + cfg_additive_step;
                     exp_limit = grown[32] ? 32'hFFFF_FFFF : grown[31:0];
                     exp_barrier_out = 1'b0;
                     exp_reply_seen = 1'b0;
                  end else begin
                     release_ok = 1'b0;
                     elapsed = r.now_ms - exp_barrier_ms;
                     if (elapsed > cfg_wait_ms) begin
                        // Timed out: shrink the limit, keep the sent count and
                        // send a fresh barrier as the only result.
                        ratio = (cfg_decrease_ratio == 0) ? 32'd1 : {24'd0, cfg_decrease_ratio};
                        bound = {32'd0, ratio} * MIN_LIMIT;
                        if ({32'd0, exp_limit} >= bound) exp_limit = exp_limit / ratio;
                        else exp_limit = MIN_LIMIT;
                        outs.push_back(make_result(aimd_bmp_pkg::RES_BARRIER, 32'd0));
                        exp_barrier_out = 1'b1;
                        exp_reply_seen = 1'b0;
                        exp_barrier_ms = r.now_ms;
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (release_ok) begin
         in_pack = 32'd0;
         while (exp_count != 0 && in_pack < exp_limit && exp_sent < exp_limit) begin
            outs.push_back(make_result(aimd_bmp_pkg::RES_FORWARD, exp_queue_mem[exp_head]));
            exp_head = exp_head + 5'd1;
            exp_count--;
            in_pack++;
            exp_sent++;
            if (in_pack == exp_limit || exp_sent == exp_limit) begin
               outs.push_back(make_result(aimd_bmp_pkg::RES_BARRIER, 32'd0));
               exp_barrier_out = 1'b1;
               exp_reply_seen = 1'b0;
               exp_barrier_ms = r.now_ms;
               exp_sent = 32'd0;
               break;
            end
         end
      end

      foreach (outs[k]) begin
         outs[k].limit_now = exp_limit;
         outs[k].last = (k == outs.size() - 1);
      end
      if (pin.pinned) begin
         outs.delete();
         outs.push_back(pin.rsp);
      end
      foreach (outs[k]) pending_results.push_back(outs[k]);
   endtask

   function automatic void field_mismatch(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
   endfunction

   task automatic check_result(input aimd_bmp_pkg::rsp_type got);
      aimd_bmp_pkg::rsp_type want;
      if (pending_results.size() == 0) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display({"%0t: unexpected result, expected none, ",
                      "actual kind %0d handle %h limit %h last %b"},
                     $time, got.result_kind, got.out_handle, got.limit_now, got.last);
         return;
      end
      want = pending_results.pop_front();
      if (got.result_kind !== want.result_kind)
         field_mismatch("result_kind", want.result_kind, got.result_kind);
      if (got.out_handle !== want.out_handle)
         field_mismatch("out_handle", want.out_handle, got.out_handle);
      if (got.limit_now !== want.limit_now)
         field_mismatch("limit_now", want.limit_now, got.limit_now);
      if (got.last !== want.last)
         field_mismatch("last", want.last, got.last);
   endtask

   // Monitor. Everything is sampled at the rising edge, so we see the values
   // that the edge itself acts on. A result at an edge always belongs to an
   // earlier request, so it is checked before a new request is predicted.
   always @(posedge clock) begin
      pinned_result_type pin;
      if (!reset) begin
         if (rsp_valid) check_result(rsp_item);
         if (start && !busy) begin
            pin = '0;
            if (pin_queue.size() != 0) pin = pin_queue.pop_front();
            pace_request(req_item, pin);
         end
      end
   end

   // Watchdog on the length of the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_aimd_barrier_message_pacer NOT OK");
         $finish;
      end
   end

   // Offers one request and returns at the edge that takes it. start is left
   // high, so a request that follows straight away goes out back to back.
   task automatic send_request(input aimd_bmp_pkg::req_type r, input pinned_result_type pin);
      pin_queue.push_back(pin);
      start <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Stops offering requests and waits until every owed result has arrived
   // and the pacer is idle. A poll that owes nothing may still be running, so
   // a stretch of the block's worst-case latency follows before anything else.
   task automatic drain_block();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0 || busy);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // A write is a setup phase and an access phase; a read-back of the same
   // register follows to check that the value stuck at the register's width.
   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      logic [31:0] mask;
      case (index)
         aimd_bmp_pkg::REG_ADDITIVE_STEP: mask = 32'h0000_FFFF;
         aimd_bmp_pkg::REG_DECREASE_RAT:  mask = 32'h0000_00FF;
         default:                         mask = 32'hFFFF_FFFF;
      endcase
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if ((prdata & mask) !== (value & mask)) field_mismatch("register read-back", value & mask,
                                                            prdata & mask);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);

      // Writing the starting limit also reloads the live limit.
      case (index)
         aimd_bmp_pkg::REG_INITIAL_LIMIT: begin
            cfg_initial_limit = value;
            exp_limit = value;
         end
         aimd_bmp_pkg::REG_ADDITIVE_STEP: cfg_additive_step = value[15:0];
         aimd_bmp_pkg::REG_DECREASE_RAT:  cfg_decrease_ratio = value[7:0];
         default:                         cfg_wait_ms = value;
      endcase
   endtask

   // Random requests are mostly well formed: a steady clock in milliseconds,
   // enqueues and polls in a ratio that both fills and empties the queue, and
   // replies often enough to close most barriers. A small share is noise with
   // any kind and any time.
   task automatic random_request(output aimd_bmp_pkg::req_type r);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      sim_ms = sim_ms + $urandom_range(0, ms_stride);
      r.msg_handle = $urandom;
      r.now_ms = sim_ms;
      if (pick < 45) r.kind = aimd_bmp_pkg::KIND_ENQUEUE;
      else if (pick < 80) r.kind = aimd_bmp_pkg::KIND_POLL;
      else if (pick < 93) r.kind = aimd_bmp_pkg::KIND_REPLY;
      else if (pick < 96) r.kind = KIND_UNUSED;
      else begin
         r.kind = 2'($urandom_range(0, 3));
         r.now_ms = $urandom;
      end
   endtask

   initial begin
      aimd_bmp_pkg::req_type req;
      pinned_result_type     pin;
      logic [31:0]           new_limit;
      logic [31:0]           new_step;
      logic [31:0]           new_ratio;
      logic [31:0]           new_wait;
      int                    issued;
      int                    burst;
      int                    gap;
      bit                    held_off;

      errors = 0;
      cycle_count = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_item <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;

      // The predictor starts from the pacer's reset state.
      cfg_initial_limit = 32'd100;
      cfg_additive_step = 16'd5;
      cfg_decrease_ratio = 8'd2;
      cfg_wait_ms = 32'd5000;
      exp_head = '0;
      exp_count = '0;
      exp_limit = 32'd100;
      exp_sent = '0;
      exp_barrier_out = 1'b0;
      exp_reply_seen = 1'b0;
      exp_barrier_ms = '0;
      sim_ms = '0;
      ms_stride = 1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: walk the table. Configuration rows only ever land on
      // an idle pacer.
      foreach (directed_table[i]) begin
         if (directed_table[i].op == ROW_CONFIG) begin
            drain_block();
            write_register(directed_table[i].sel, directed_table[i].arg_a);
         end else begin
            for (int n = 0; n < directed_table[i].reps; n++) begin
               req.kind = directed_table[i].sel;
               req.msg_handle = directed_table[i].arg_a + n;
               req.now_ms = directed_table[i].arg_b;
               pin.pinned = directed_table[i].pinned;
               pin.rsp = '{result_kind: directed_table[i].pin_kind,
                           out_handle: directed_table[i].pin_handle,
                           limit_now: directed_table[i].pin_limit,
                           last: 1'b1};
               send_request(req, pin);
            end
         end
      end

      // Random part in phases. The first phase takes step and wait at zero and
      // limit and ratio at one, the second the highest setting of every register;
      // the rest are random, with small limits and short waits so that packs,
      // timeouts and drops happen often. The third phase starts its clock near wrap.
      pin = '0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_block();
         case (phase)
            0: begin
               new_limit = 32'd1;
               new_step = 32'd0;
               new_ratio = 32'd1;
               new_wait = 32'd0;
            end
            1: begin
               new_limit = 32'hFFFF_FFFF;
               new_step = 32'h0000_FFFF;
               new_ratio = 32'd255;
               new_wait = 32'hFFFF_FFFF;
            end
            default: begin
               new_limit = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 40);
               new_step = $urandom_range(0, 40);
               new_ratio = $urandom_range(0, 5);
               new_wait = $urandom_range(0, 200);
            end
         endcase
         write_register(aimd_bmp_pkg::REG_INITIAL_LIMIT, new_limit);
         write_register(aimd_bmp_pkg::REG_ADDITIVE_STEP, new_step);
         write_register(aimd_bmp_pkg::REG_DECREASE_RAT, new_ratio);
         write_register(aimd_bmp_pkg::REG_WAIT_INTERVAL, new_wait);
         ms_stride = (cfg_wait_ms > 400) ? 50 : cfg_wait_ms / 2 + 3;
         sim_ms = (phase == 2) ? 32'hFFFF_FF80 : $urandom;

         issued = 0;
         held_off = 1'b0;
         burst = $urandom_range(1, 16);
         while (issued < ITEMS_PER_PHASE) begin
            random_request(req);
            send_request(req, pin);
            if (req.kind != KIND_UNUSED) issued++;
            burst--;
            if (!held_off && issued >= ITEMS_PER_PHASE / 2) begin
               // Halfway through, the sender holds off until nothing is owed.
               held_off = 1'b1;
               drain_block();
            end else if (burst == 0) begin
               // Bursts mostly end with a gap with start low, or sometimes none.
               burst = $urandom_range(1, 16);
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               if (gap > 0) begin
                  start <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
         end
      end

      drain_block();
      if (errors == 0) $display("tb_aimd_barrier_message_pacer OK");
      else $display("tb_aimd_barrier_message_pacer NOT OK");
      $finish;
   end

endmodule
